@@ src/tkn_pkg.sv @@
// Shared types and constants for the token scanner.
// Used by tkn_front, tkn_fifo, tkn_back and token_scanner; depends on nothing.
`default_nettype none

package tkn_pkg;

  // Scanner limits
  localparam int MAX_WORD_LEN = 12;  // word flagged once this many chars are kept
  localparam int MAX_DIGITS   = 6;   // digit past this count flags the number
  localparam int NUM_RESERVED = 8;   // reserved-word registers that take part in matching
  localparam int RSV_COUNT    = 8;   // reserved-word registers on the config port
  localparam int RSV_MAX_LEN  = 6;   // longest word that fits a 48-bit register
  localparam int HEAD_BYTES   = 8;   // word characters kept in word_head

  // Field widths
  localparam int CHAR_W  = 8;
  localparam int LINE_W  = 20;
  localparam int LEN_W   = 4;
  localparam int VAL_W   = 24;
  localparam int HEAD_W  = 64;
  localparam int RSV_W   = 48;
  localparam int RIDX_W  = 3;
  localparam int DCNT_W  = 4;
  localparam int WCNT_W  = 5;

  localparam logic [LINE_W-1:0] LINE_MAX = '1;

  // Characters of interest
  localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE    = 8'h39;
  localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
  localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_BANG    = 8'h21;
  localparam logic [CHAR_W-1:0] CH_EQUAL   = 8'h3D;
  localparam logic [CHAR_W-1:0] CH_LC_A    = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LC_Z    = 8'h7A;
  localparam logic [CHAR_W-1:0] CH_UC_A    = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UC_Z    = 8'h5A;

  // Reserved-word reset values: if, while, for, int, return, void, main, and one name
  localparam logic [RSV_W-1:0] RSV_RESET [RSV_COUNT] = '{
    48'd26217, 48'd435610544247, 48'd7499622, 48'd7630441,
    48'd121437875889522, 48'd1684631414, 48'd1852399981, 48'd107105451337811
  };

  // Queue between front and back
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;
  localparam int FIFO_CW    = 3;

  typedef enum logic [2:0] {
    KIND_NUMBER    = 3'd0,
    KIND_WORD      = 3'd1,
    KIND_RESERVED  = 3'd2,
    KIND_OPERATOR  = 3'd3,
    KIND_NUM_LONG  = 3'd4,
    KIND_WORD_LONG = 3'd5,
    KIND_BAD_OP    = 3'd6
  } kind_e;

  // One classified token as the front hands it over
  typedef struct packed {
    kind_e               kind;
    logic [LEN_W-1:0]    len;
    logic [VAL_W-1:0]    value;
    logic [HEAD_W-1:0]   head;
    logic [CHAR_W-1:0]   opc;
    logic                ne;
    logic                chk;    // word eligible for reserved-word match
  } rec_t;

  // Everything one input beat produces: one or two tokens on the same line
  typedef struct packed {
    logic [LINE_W-1:0]   line;
    rec_t                a;
    logic                b_vld;
    rec_t                b;
  } entry_t;

  // One result beat
  typedef struct packed {
    kind_e               kind;
    logic [LINE_W-1:0]   line;
    logic [LEN_W-1:0]    len;
    logic [VAL_W-1:0]    value;
    logic [HEAD_W-1:0]   head;
    logic [RIDX_W-1:0]   ridx;
    logic [CHAR_W-1:0]   opc;
    logic                ne;
    logic                last;
  } res_t;

endpackage

`default_nettype wire

@@ src/tkn_front.sv @@
// Front end of the token scanner: accepts character beats, tracks the scan state
// and hands one entry of up to two tokens to the queue. Depends on tkn_pkg.
`default_nettype none

module tkn_front (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire logic [tkn_pkg::CHAR_W-1:0] in_char_i,
  input  wire logic                      end_of_input_i,
  input  wire logic                      q_full_i,
  output logic                           push_o,
  output tkn_pkg::entry_t                entry_o
);
  import tkn_pkg::*;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_NUM  = 2'd1,
    MODE_WORD = 2'd2,
    MODE_BANG = 2'd3
  } mode_e;

  mode_e               mode_q, mode_d;
  logic [DCNT_W-1:0]   dcnt_q, dcnt_d;
  logic [VAL_W-1:0]    val_q, val_d;
  logic [WCNT_W-1:0]   wcnt_q, wcnt_d;
  logic [HEAD_W-1:0]   buf_q, buf_d;
  logic                skip_q, skip_d;
  logic [LINE_W-1:0]   line_q, line_d;

  logic                accept;
  logic                is_dig, is_let;
  logic                fl_vld;
  rec_t                fl_rec, op_rec, ne_rec;
  logic                st_op;
  logic [DCNT_W-1:0]   dcnt_inc;
  logic [WCNT_W-1:0]   wcnt_inc;
  logic [VAL_W-1:0]    val_next;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  assign is_dig = (in_char_i >= CH_ZERO) && (in_char_i <= CH_NINE);
  assign is_let = ((in_char_i >= CH_LC_A) && (in_char_i <= CH_LC_Z)) ||
                  ((in_char_i >= CH_UC_A) && (in_char_i <= CH_UC_Z));

  assign dcnt_inc = dcnt_q + DCNT_W'(1);
  assign wcnt_inc = wcnt_q + WCNT_W'(1);
  // times ten as two shifts, then add the digit; digits '0'..'9' carry their value in the low nibble
  assign val_next = (val_q << 3) + (val_q << 1) + VAL_W'(in_char_i[3:0]);

  // Pending token, as a flush would report it
  always_comb begin
    fl_rec = '0;
    fl_vld = 1'b0;
    case (mode_q)
      MODE_NUM: begin
        fl_vld       = 1'b1;
        fl_rec.kind  = skip_q ? KIND_NUM_LONG : KIND_NUMBER;
        fl_rec.len   = dcnt_q;
        fl_rec.value = val_q;
      end
      MODE_WORD: begin
        fl_vld      = 1'b1;
        fl_rec.kind = skip_q ? KIND_WORD_LONG : KIND_WORD;
        fl_rec.len  = wcnt_q[LEN_W-1:0];
        fl_rec.head = buf_q;
        fl_rec.chk  = !skip_q && (wcnt_q <= WCNT_W'(RSV_MAX_LEN));
      end
      MODE_BANG: begin
        fl_vld      = 1'b1;
        fl_rec.kind = KIND_BAD_OP;
        fl_rec.opc  = CH_BANG;
      end
      default: begin
        fl_vld = 1'b0;
      end
    endcase
  end

  // Single-character operator and the != pair
  always_comb begin
    op_rec      = '0;
    op_rec.kind = KIND_OPERATOR;
    op_rec.opc  = in_char_i;
    ne_rec      = '0;
    ne_rec.kind = KIND_OPERATOR;
    ne_rec.opc  = CH_BANG;
    ne_rec.ne   = 1'b1;
  end

  assign st_op = !is_dig && !is_let && (in_char_i != CH_SPACE) &&
                 (in_char_i != CH_NEWLINE) && (in_char_i != CH_BANG);

  always_comb begin
    mode_d  = mode_q;
    dcnt_d  = dcnt_q;
    val_d   = val_q;
    wcnt_d  = wcnt_q;
    buf_d   = buf_q;
    skip_d  = skip_q;
    line_d  = line_q;
    push_o  = 1'b0;
    entry_o = '0;
    entry_o.line = line_q;

    if (end_of_input_i) begin
      // flush and go back to idle
      push_o    = accept && fl_vld;
      entry_o.a = fl_rec;
      mode_d    = MODE_IDLE;
      skip_d    = 1'b0;
    end else if (mode_q == MODE_NUM && is_dig) begin
      if (!skip_q) begin
        dcnt_d = dcnt_inc;
        val_d  = val_next;
        if (dcnt_inc > DCNT_W'(MAX_DIGITS)) begin
          skip_d = 1'b1;
        end
      end
    end else if (mode_q == MODE_WORD && (is_dig || is_let)) begin
      if (!skip_q) begin
        if (wcnt_q < WCNT_W'(HEAD_BYTES)) begin
          buf_d[{wcnt_q[2:0], 3'b000} +: CHAR_W] = in_char_i;
        end
        wcnt_d = wcnt_inc;
        if (wcnt_inc >= WCNT_W'(MAX_WORD_LEN)) begin
          skip_d = 1'b1;
        end
      end
    end else if (mode_q == MODE_BANG && in_char_i == CH_EQUAL) begin
      push_o    = accept;
      entry_o.a = ne_rec;
      mode_d    = MODE_IDLE;
    end else begin
      // end the pending token, then start over with this character
      push_o        = accept && (fl_vld || st_op);
      entry_o.a     = fl_vld ? fl_rec : op_rec;
      entry_o.b_vld = fl_vld && st_op;
      entry_o.b     = op_rec;
      mode_d        = MODE_IDLE;
      skip_d        = 1'b0;
      if (in_char_i == CH_NEWLINE) begin
        if (line_q < LINE_MAX) begin
          line_d = line_q + LINE_W'(1);
        end
      end else if (is_dig) begin
        mode_d = MODE_NUM;
        dcnt_d = DCNT_W'(1);
        val_d  = VAL_W'(in_char_i[3:0]);
      end else if (is_let) begin
        mode_d = MODE_WORD;
        wcnt_d = WCNT_W'(1);
        buf_d  = HEAD_W'(in_char_i);
      end else if (in_char_i == CH_BANG) begin
        mode_d = MODE_BANG;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      dcnt_q <= '0;
      val_q  <= '0;
      wcnt_q <= '0;
      buf_q  <= '0;
      skip_q <= 1'b0;
      line_q <= LINE_W'(1);
    end else if (accept) begin
      mode_q <= mode_d;
      dcnt_q <= dcnt_d;
      val_q  <= val_d;
      wcnt_q <= wcnt_d;
      buf_q  <= buf_d;
      skip_q <= skip_d;
      line_q <= line_d;
    end
  end

endmodule

`default_nettype wire

@@ src/tkn_fifo.sv @@
// Short queue of token entries between the scanner front and back.
// Depends on tkn_pkg for the entry type and depth.
`default_nettype none

module tkn_fifo (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire tkn_pkg::entry_t  entry_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic                  head_vld_o,
  output tkn_pkg::entry_t       head_o
);
  import tkn_pkg::*;

  entry_t               mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_q, rd_q;
  logic [FIFO_CW-1:0]   cnt_q;
  logic                 do_push, do_pop;

  assign full_o     = (cnt_q == FIFO_CW'(FIFO_DEPTH));
  assign head_vld_o = (cnt_q != '0);
  assign head_o     = mem_q[rd_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && head_vld_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= wr_q + FIFO_AW'(1);
      end
      if (do_pop) begin
        rd_q <= rd_q + FIFO_AW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + FIFO_CW'(1);
        2'b01:   cnt_q <= cnt_q - FIFO_CW'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ src/tkn_back.sv @@
// Back end of the token scanner: holds the reserved-word registers, matches words,
// splits each queue entry into result beats and drives the output register.
// Depends on tkn_pkg.
`default_nettype none

module tkn_back (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [tkn_pkg::RIDX_W-1:0] cfg_idx_i,
  input  wire logic [tkn_pkg::RSV_W-1:0]  cfg_wdata_i,
  input  wire logic                       head_vld_i,
  input  wire tkn_pkg::entry_t            head_i,
  output logic                            pop_o,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output tkn_pkg::res_t                   res_o
);
  import tkn_pkg::*;

  logic [RSV_W-1:0]   rsv_q [RSV_COUNT];
  res_t               res_q;
  logic               out_vld_q;
  res_t               pend_q;
  logic               pend_vld_q;
  logic               load;
  logic               hit;
  logic [RIDX_W-1:0]  hit_idx;
  res_t               a_res, b_res;

  // Lowest matching register wins: scan from the top down
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = NUM_RESERVED - 1; i >= 0; i--) begin
      if (head_i.a.head[RSV_W-1:0] == rsv_q[i]) begin
        hit     = 1'b1;
        hit_idx = RIDX_W'(i);
      end
    end
  end

  always_comb begin
    a_res       = '0;
    a_res.kind  = (head_i.a.chk && hit) ? KIND_RESERVED : head_i.a.kind;
    a_res.line  = head_i.line;
    a_res.len   = head_i.a.len;
    a_res.value = head_i.a.value;
    a_res.head  = head_i.a.head;
    a_res.ridx  = (head_i.a.chk && hit) ? hit_idx : '0;
    a_res.opc   = head_i.a.opc;
    a_res.ne    = head_i.a.ne;
    a_res.last  = !head_i.b_vld;

    b_res       = '0;
    b_res.kind  = head_i.b.kind;
    b_res.line  = head_i.line;
    b_res.len   = head_i.b.len;
    b_res.value = head_i.b.value;
    b_res.head  = head_i.b.head;
    b_res.opc   = head_i.b.opc;
    b_res.ne    = head_i.b.ne;
    b_res.last  = 1'b1;
  end

  // Refill the output register when it is empty or being taken
  assign load  = !out_vld_q || out_ready_i;
  assign pop_o = load && !pend_vld_q && head_vld_i;

  assign out_valid_o = out_vld_q;
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      pend_vld_q <= 1'b0;
    end else if (load) begin
      if (pend_vld_q) begin
        out_vld_q  <= 1'b1;
        pend_vld_q <= 1'b0;
      end else begin
        out_vld_q  <= head_vld_i;
        pend_vld_q <= head_vld_i && head_i.b_vld;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      if (pend_vld_q) begin
        res_q <= pend_q;
      end else if (head_vld_i) begin
        res_q  <= a_res;
        pend_q <= b_res;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < RSV_COUNT; i++) begin
        rsv_q[i] <= RSV_RESET[i];
      end
    end else if (cfg_we_i) begin
      rsv_q[cfg_idx_i] <= cfg_wdata_i;
    end
  end

endmodule

`default_nettype wire

@@ src/token_scanner.sv @@
// Token scanner top level: front end, entry queue and back end.
// Depends on tkn_pkg, tkn_front, tkn_fifo and tkn_back.
//
// The scanner takes one character beat per cycle while its queue has room and emits
// token beats. Each input beat carries an ASCII byte and an end-of-input flag.
// Spaces are dropped, newlines are dropped and advance the line counter (starting at
// one, saturating). Digit runs become numbers, letter-led alphanumeric runs become
// words, words are matched against eight 48-bit reserved-word registers, "!=" is one
// operator, a lone "!" is a bad operator and any other byte is a one-character
// operator. The byte that ends a number, word or lone "!" also starts the next token,
// so one input beat can yield two result beats; last_o marks the final beat of each
// input beat. The front end classifies a character beat combinationally and writes
// one entry per producing beat into a four-entry queue; the back end matches
// reserved words and releases one result beat per cycle from its output register
// unless out_ready_i holds it back. Input beats are taken every cycle as long as the
// queue has room: sustained rate is one input beat per cycle, bounded by one result
// beat per cycle on the output side, so a stream in which every character ends a
// token and is an operator is held back by the output side. Write the reserved-word
// registers through cfg_we_i / cfg_idx_i / cfg_wdata_i only while no tokens are in
// flight; a write takes effect on the next cycle.
`default_nettype none

module token_scanner (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  // configuration writes
  input  wire logic                       cfg_we_i,
  input  wire logic [tkn_pkg::RIDX_W-1:0] cfg_idx_i,
  input  wire logic [tkn_pkg::RSV_W-1:0]  cfg_wdata_i,
  // character beats
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic [tkn_pkg::CHAR_W-1:0] in_char_i,
  input  wire logic                       end_of_input_i,
  // token beats
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic [2:0]                      kind_o,
  output logic [tkn_pkg::LINE_W-1:0]      line_o,
  output logic [tkn_pkg::LEN_W-1:0]       token_length_o,
  output logic [tkn_pkg::VAL_W-1:0]       number_value_o,
  output logic [tkn_pkg::HEAD_W-1:0]      word_head_o,
  output logic [tkn_pkg::RIDX_W-1:0]      reserved_index_o,
  output logic [tkn_pkg::CHAR_W-1:0]      operator_char_o,
  output logic                            is_not_equal_o,
  output logic                            last_o
);
  import tkn_pkg::*;

  logic    push;
  entry_t  push_entry;
  logic    q_full;
  logic    pop;
  logic    head_vld;
  entry_t  head;
  res_t    res;

  // Classify characters and track the token under construction
  tkn_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .in_char_i      (in_char_i),
    .end_of_input_i (end_of_input_i),
    .q_full_i       (q_full),
    .push_o         (push),
    .entry_o        (push_entry)
  );

  // Decouple the two sides so either can stall on its own
  tkn_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .entry_i    (push_entry),
    .full_o     (q_full),
    .pop_i      (pop),
    .head_vld_o (head_vld),
    .head_o     (head)
  );

  // Match reserved words and serialize entries into result beats
  tkn_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .head_vld_i  (head_vld),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res)
  );

  assign kind_o           = res.kind;
  assign line_o           = res.line;
  assign token_length_o   = res.len;
  assign number_value_o   = res.value;
  assign word_head_o      = res.head;
  assign reserved_index_o = res.ridx;
  assign operator_char_o  = res.opc;
  assign is_not_equal_o   = res.ne;
  assign last_o           = res.last;

endmodule

`default_nettype wire

@@ tb/token_checker.sv @@
// Token checker: watches the character, token and register-write ports of the scanner,
// predicts the token beats and compares them. Depends on tkn_pkg.
`timescale 1ns / 100ps

module token_checker
  import tkn_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [RIDX_W-1:0] cfg_idx_i,
  input  wire logic [RSV_W-1:0]  cfg_wdata_i,
  input  wire logic              in_valid_i,
  input  wire logic              in_ready_i,
  input  wire logic [CHAR_W-1:0] in_char_i,
  input  wire logic              end_of_input_i,
  input  wire logic              out_valid_i,
  input  wire logic              out_ready_i,
  input  wire logic [2:0]        kind_i,
  input  wire logic [LINE_W-1:0] line_i,
  input  wire logic [LEN_W-1:0]  token_length_i,
  input  wire logic [VAL_W-1:0]  number_value_i,
  input  wire logic [HEAD_W-1:0] word_head_i,
  input  wire logic [RIDX_W-1:0] reserved_index_i,
  input  wire logic [CHAR_W-1:0] operator_char_i,
  input  wire logic              is_not_equal_i,
  input  wire logic              last_i,
  output int unsigned            fail_count_o,
  output int unsigned            tokens_pending_o,
  output int unsigned            tokens_checked_o
);

  localparam int MAX_REPORTS = 10;

  typedef enum logic [1:0] {SCAN_IDLE, SCAN_NUM, SCAN_WORD, SCAN_BANG} scan_e;

  // Scanner state as predicted
  logic [RSV_W-1:0]  rsv_words [RSV_COUNT];
  scan_e             mode;
  logic [DCNT_W-1:0] n_digits;
  logic [VAL_W-1:0]  acc;
  logic [WCNT_W-1:0] n_chars;
  logic [HEAD_W-1:0] head_buf;
  logic              skip;
  logic [LINE_W-1:0] line_no;

  res_t        token_q [$];
  res_t        beat_toks [$];
  int unsigned fails;
  int unsigned reports;
  int unsigned checked;

  function automatic logic is_digit(input logic [CHAR_W-1:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic logic is_letter(input logic [CHAR_W-1:0] c);
    return (c >= CH_LC_A && c <= CH_LC_Z) || (c >= CH_UC_A && c <= CH_UC_Z);
  endfunction

  task automatic add_token(input kind_e k, input logic [LEN_W-1:0] len,
                           input logic [VAL_W-1:0] val, input logic [HEAD_W-1:0] head,
                           input logic [RIDX_W-1:0] ridx, input logic [CHAR_W-1:0] opc,
                           input logic ne);
    res_t t;
    t.kind  = k;
    t.line  = line_no;
    t.len   = len;
    t.value = val;
    t.head  = head;
    t.ridx  = ridx;
    t.opc   = opc;
    t.ne    = ne;
    t.last  = 1'b0;
    beat_toks.push_back(t);
  endtask

  // Emit whatever token is open and go back to idle
  task automatic flush_pending();
    kind_e           k;
    logic [RIDX_W-1:0] idx;
    logic            hit;
    logic [RIDX_W:0] i;
    case (mode)
      SCAN_NUM: begin
        k = skip ? KIND_NUM_LONG : KIND_NUMBER;
        add_token(k, n_digits[LEN_W-1:0], acc, '0, '0, '0, 1'b0);
      end
      SCAN_WORD: begin
        k   = KIND_WORD;
        idx = '0;
        hit = 1'b0;
        if (skip) begin
          k = KIND_WORD_LONG;
        end else if (n_chars <= RSV_MAX_LEN) begin
          // lowest matching register wins
          for (i = 0; i < NUM_RESERVED; i++) begin
            if (!hit && head_buf[RSV_W-1:0] == rsv_words[i[RIDX_W-1:0]]) begin
              hit = 1'b1;
              k   = KIND_RESERVED;
              idx = i[RIDX_W-1:0];
            end
          end
        end
        add_token(k, n_chars[LEN_W-1:0], '0, head_buf, idx, '0, 1'b0);
      end
      SCAN_BANG: add_token(KIND_BAD_OP, '0, '0, '0, '0, CH_BANG, 1'b0);
      default: ;
    endcase
    mode = SCAN_IDLE;
    skip = 1'b0;
  endtask

  task automatic predict_beat(input logic [CHAR_W-1:0] c, input logic eoi);
    int unsigned n;
    res_t        t;
    beat_toks.delete();
    if (eoi) begin
      flush_pending();
    end else if (mode == SCAN_NUM && is_digit(c)) begin
      if (!skip) begin
        n_digits++;
        acc = VAL_W'(acc * 10 + (c - CH_ZERO));
        if (n_digits > MAX_DIGITS) skip = 1'b1;
      end
    end else if (mode == SCAN_WORD && (is_letter(c) || is_digit(c))) begin
      if (!skip) begin
        if (n_chars < HEAD_BYTES) head_buf[8*n_chars +: 8] = c;
        n_chars++;
        if (n_chars >= MAX_WORD_LEN) skip = 1'b1;
      end
    end else if (mode == SCAN_BANG && c == CH_EQUAL) begin
      add_token(KIND_OPERATOR, '0, '0, '0, '0, CH_BANG, 1'b1);
      mode = SCAN_IDLE;
    end else begin
      // the terminating character opens the next token
      flush_pending();
      if (c == CH_SPACE) begin
      end else if (c == CH_NEWLINE) begin
        if (line_no != LINE_MAX) line_no++;
      end else if (is_digit(c)) begin
        mode     = SCAN_NUM;
        n_digits = DCNT_W'(1);
        acc      = VAL_W'(c - CH_ZERO);
        skip     = 1'b0;
      end else if (is_letter(c)) begin
        mode     = SCAN_WORD;
        n_chars  = WCNT_W'(1);
        head_buf = '0;
        head_buf[CHAR_W-1:0] = c;
        skip     = 1'b0;
      end else if (c == CH_BANG) begin
        mode = SCAN_BANG;
      end else begin
        add_token(KIND_OPERATOR, '0, '0, '0, '0, c, 1'b0);
      end
    end
    n = beat_toks.size();
    for (int j = 0; j < n; j++) begin
      t      = beat_toks[j];
      t.last = (j == n - 1);
      token_q.push_back(t);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    res_t want;
    res_t got;
    logic bad;
    if (!rst_ni) begin
      for (int i = 0; i < RSV_COUNT; i++) rsv_words[i] = RSV_RESET[i];
      mode     = SCAN_IDLE;
      n_digits = '0;
      acc      = '0;
      n_chars  = '0;
      head_buf = '0;
      skip     = 1'b0;
      line_no  = LINE_W'(1);
      token_q.delete();
      fails    = 0;
      reports  = 0;
      checked  = 0;
      fail_count_o     <= 0;
      tokens_pending_o <= 0;
      tokens_checked_o <= 0;
    end else begin
      if (cfg_we_i) rsv_words[cfg_idx_i] = cfg_wdata_i;
      if (in_valid_i && in_ready_i) predict_beat(in_char_i, end_of_input_i);
      if (out_valid_i && out_ready_i) begin
        got.kind  = kind_e'(kind_i);
        got.line  = line_i;
        got.len   = token_length_i;
        got.value = number_value_i;
        got.head  = word_head_i;
        got.ridx  = reserved_index_i;
        got.opc   = operator_char_i;
        got.ne    = is_not_equal_i;
        got.last  = last_i;
        checked++;
        if (token_q.size() == 0) begin
          fails++;
          if (reports < MAX_REPORTS) begin
            reports++;
            $display("token_checker: token beat %0d with nothing expected (kind %0d line %0d)",
                     checked, kind_i, line_i);
          end
        end else begin
          want = token_q.pop_front();
          bad  = got.kind != want.kind || got.line != want.line || got.len != want.len ||
                 got.value != want.value || got.head != want.head ||
                 got.ridx != want.ridx || got.opc != want.opc ||
                 got.ne != want.ne || got.last != want.last;
          if (bad) begin
            fails++;
            if (reports < MAX_REPORTS) begin
              reports++;
              $display("token_checker: mismatch on token beat %0d", checked);
              $display("  expected kind=%0d line=%0d len=%0d value=%0d head=%h",
                       want.kind, want.line, want.len, want.value, want.head);
              $display("           ridx=%0d op=%h ne=%b last=%b",
                       want.ridx, want.opc, want.ne, want.last);
              $display("  actual   kind=%0d line=%0d len=%0d value=%0d head=%h",
                       got.kind, got.line, got.len, got.value, got.head);
              $display("           ridx=%0d op=%h ne=%b last=%b",
                       got.ridx, got.opc, got.ne, got.last);
            end
          end
        end
      end
      fail_count_o     <= fails;
      tokens_pending_o <= token_q.size();
      tokens_checked_o <= checked;
    end
  end

endmodule

@@ tb/tb_top.sv @@
// Top of the token scanner testbench: clock, reset, character and register stimulus,
// random token-port stalls and the verdict. Depends on tkn_pkg, token_scanner, token_checker.
`timescale 1ns / 100ps

module tb_top;
  import tkn_pkg::*;

  // Clock, reset and every block input start at a known value
  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              cfg_we    = 1'b0;
  logic [RIDX_W-1:0] cfg_idx   = '0;
  logic [RSV_W-1:0]  cfg_wdata = '0;
  logic              in_valid  = 1'b0;
  logic [CHAR_W-1:0] in_char   = '0;
  logic              eoi       = 1'b0;
  logic              out_ready = 1'b0;

  logic              in_ready;
  logic              out_valid;
  logic [2:0]        tok_kind;
  logic [LINE_W-1:0] tok_line;
  logic [LEN_W-1:0]  tok_len;
  logic [VAL_W-1:0]  tok_value;
  logic [HEAD_W-1:0] tok_head;
  logic [RIDX_W-1:0] tok_ridx;
  logic [CHAR_W-1:0] tok_opc;
  logic              tok_ne;
  logic              tok_last;

  int unsigned fail_count;
  int unsigned tokens_pending;
  int unsigned tokens_checked;

  // Stimulus bookkeeping
  logic [RSV_W-1:0] vocab [RSV_COUNT];       // what the registers hold now
  logic [RSV_W-1:0] next_words [RSV_COUNT];  // next register setting
  logic             no_gaps  = 1'b0;
  int unsigned      beats_sent = 0;
  int unsigned      settings   = 0;

  token_scanner dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .in_char_i       (in_char),
    .end_of_input_i  (eoi),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .kind_o          (tok_kind),
    .line_o          (tok_line),
    .token_length_o  (tok_len),
    .number_value_o  (tok_value),
    .word_head_o     (tok_head),
    .reserved_index_o(tok_ridx),
    .operator_char_o (tok_opc),
    .is_not_equal_o  (tok_ne),
    .last_o          (tok_last)
  );

  token_checker u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata),
    .in_valid_i      (in_valid),
    .in_ready_i      (in_ready),
    .in_char_i       (in_char),
    .end_of_input_i  (eoi),
    .out_valid_i     (out_valid),
    .out_ready_i     (out_ready),
    .kind_i          (tok_kind),
    .line_i          (tok_line),
    .token_length_i  (tok_len),
    .number_value_i  (tok_value),
    .word_head_i     (tok_head),
    .reserved_index_i(tok_ridx),
    .operator_char_i (tok_opc),
    .is_not_equal_i  (tok_ne),
    .last_i          (tok_last),
    .fail_count_o    (fail_count),
    .tokens_pending_o(tokens_pending),
    .tokens_checked_o(tokens_checked)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Hold reset low from the start, then release it for good
  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Hard stop for a hung run: several times what the run takes with every
  // beat giving two tokens and every stall at its longest
  initial begin
    #(20_000_000);
    $display("tb: failure");
    $finish;
  end

  // Idle length: mostly none or short, now and then a long one
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic is_alpha(input logic [CHAR_W-1:0] c);
    return (c >= CH_LC_A && c <= CH_LC_Z) || (c >= CH_UC_A && c <= CH_UC_Z);
  endfunction

  function automatic logic [CHAR_W-1:0] rand_letter();
    if ($urandom_range(0, 1) != 0) return CH_LC_A + CHAR_W'($urandom_range(0, 25));
    return CH_UC_A + CHAR_W'($urandom_range(0, 25));
  endfunction

  function automatic logic [CHAR_W-1:0] rand_alnum();
    if ($urandom_range(0, 3) == 0) return CH_ZERO + CHAR_W'($urandom_range(0, 9));
    return rand_letter();
  endfunction

  // Packed word, first character in the low byte, zero padded
  function automatic logic [RSV_W-1:0] rand_word(input int unsigned n);
    logic [RSV_W-1:0] w;
    w = '0;
    for (int k = 0; k < n; k++) w[8*k +: 8] = (k == 0) ? rand_letter() : rand_alnum();
    return w;
  endfunction

  // Present one character beat and hold it until the scanner takes it.
  // Called at a rising edge; in_ready is read just after the edge, so it is
  // the value the scanner had during the cycle that ended there.
  task automatic send_beat(input logic [CHAR_W-1:0] c, input logic flush);
    int unsigned g;
    g = no_gaps ? 0 : gap_len();
    if (g != 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_char  <= c;
    eoi      <= flush;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    beats_sent++;
  endtask

  task automatic send_text(input string s);
    for (int k = 0; k < s.len(); k++) send_beat(s[k], 1'b0);
  endtask

  // Drop valid and wait until every predicted token has come out, then let
  // the pipeline settle
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tokens_pending != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // Write all reserved-word registers from next_words; only while drained
  task automatic load_words();
    logic [RIDX_W:0] r;
    for (r = 0; r < RSV_COUNT; r++) begin
      cfg_we    <= 1'b1;
      cfg_idx   <= r[RIDX_W-1:0];
      cfg_wdata <= next_words[r[RIDX_W-1:0]];
      vocab[r[RIDX_W-1:0]] = next_words[r[RIDX_W-1:0]];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    settings++;
    @(posedge clk);
  endtask

  // One well-formed token with random content, sometimes noise, then a separator or none
  task automatic emit_token();
    int unsigned      pick;
    int unsigned      n;
    logic [CHAR_W-1:0] b;
    logic [RSV_W-1:0] w;
    pick = $urandom_range(0, 99);
    if (pick < 22) begin
      // plain word; some long enough to hit the length limit
      n = ($urandom_range(0, 5) == 0) ? $urandom_range(8, 16) : $urandom_range(1, 7);
      send_beat(rand_letter(), 1'b0);
      for (int k = 1; k < n; k++) send_beat(rand_alnum(), 1'b0);
    end else if (pick < 42) begin
      // word taken from a register, sometimes extended so it no longer matches
      w = vocab[$urandom_range(0, RSV_COUNT - 1)];
      if (!is_alpha(w[7:0])) w = rand_word($urandom_range(1, RSV_MAX_LEN));
      for (int k = 0; k < RSV_MAX_LEN && w[8*k +: 8] != 8'h00; k++) send_beat(w[8*k +: 8], 1'b0);
      if ($urandom_range(0, 4) == 0) send_beat(rand_alnum(), 1'b0);
    end else if (pick < 62) begin
      // number; a few run past the digit limit
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 11) : $urandom_range(1, 6);
      for (int k = 0; k < n; k++) send_beat(CH_ZERO + CHAR_W'($urandom_range(0, 9)), 1'b0);
    end else if (pick < 76) begin
      // single-byte operator, control bytes and the upper half included
      b = CHAR_W'($urandom_range(0, 255));
      while (is_alpha(b) || (b >= CH_ZERO && b <= CH_NINE) || b == CH_SPACE ||
             b == CH_NEWLINE || b == CH_BANG)
        b = CHAR_W'($urandom_range(0, 255));
      send_beat(b, 1'b0);
    end else if (pick < 84) begin
      send_beat(CH_BANG, 1'b0);
      send_beat(CH_EQUAL, 1'b0);
    end else if (pick < 89) begin
      // lone bang: whatever comes next decides
      send_beat(CH_BANG, 1'b0);
    end else if (pick < 94) begin
      // end of input with a random byte that must be ignored
      send_beat(CHAR_W'($urandom_range(0, 255)), 1'b1);
    end else begin
      send_beat(CHAR_W'($urandom_range(0, 255)), 1'b0);
    end
    // separator: space, newline, or none so the next token ends this one
    pick = $urandom_range(0, 9);
    if (pick < 4) send_beat(CH_SPACE, 1'b0);
    else if (pick < 5) send_beat(CH_NEWLINE, 1'b0);
    // switch now and then between gappy and back-to-back streams
    if ($urandom_range(0, 49) == 0) no_gaps = !no_gaps;
  endtask

  task automatic random_run(input int unsigned count);
    int unsigned stop_at;
    stop_at = beats_sent + count;
    while (beats_sent < stop_at) begin
      emit_token();
      // pause the stream now and then until the token side has caught up
      if ($urandom_range(0, 149) == 0) drain();
    end
    no_gaps = 1'b0;
  endtask

  // Token side: stall for a random gap, then accept for a random run
  initial begin : sink
    int unsigned n;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      n = gap_len();
      if (n != 0) begin
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(0, 9) == 0 ? $urandom_range(100, 300) : $urandom_range(1, 8))
        @(posedge clk);
    end
  end

  initial begin : stimulus
    wait (rst_n === 1'b1);
    @(posedge clk);
    for (int k = 0; k < RSV_COUNT; k++) vocab[k] = RSV_RESET[k];

    // Directed: reserved word ended by an operator (two tokens from one beat),
    // twelve-character word ended by "!=", seven-digit number flushed by end of
    // input, lone bang ended by newline, end of input with nothing open,
    // and the lowest and highest byte as operators
    send_text("if(");
    send_text("Zz9aaaaaaaaa!=");
    send_text("9876543");
    send_beat(8'hFF, 1'b1);
    send_text("!\n");
    send_beat(CH_ZERO, 1'b1);
    send_beat(8'h00, 1'b0);
    send_beat(8'hFF, 1'b0);
    drain();

    // Registers at their reset words
    random_run(400);
    drain();

    // Shortest and longest words, an empty and an all-ones register, and a
    // duplicate so the lower register has to win
    next_words[0] = rand_word(1);
    next_words[1] = rand_word(RSV_MAX_LEN);
    next_words[2] = '0;
    next_words[3] = '1;
    next_words[4] = rand_word(3);
    next_words[5] = rand_word(2);
    next_words[6] = next_words[4];
    next_words[7] = rand_word(RSV_MAX_LEN);
    load_words();
    random_run(450);
    drain();

    // Nothing can match
    for (int k = 0; k < RSV_COUNT; k++) next_words[k] = '0;
    load_words();
    random_run(300);
    drain();

    // Random words, one register with a raw random value
    for (int k = 0; k < RSV_COUNT; k++) next_words[k] = rand_word($urandom_range(1, RSV_MAX_LEN));
    next_words[$urandom_range(0, RSV_COUNT - 1)] = RSV_W'({$urandom, $urandom});
    load_words();
    random_run(540);
    send_beat(CH_SPACE, 1'b1);
    drain();

    $display("tb: %0d character beats sent, %0d token beats checked",
             beats_sent, tokens_checked);
    $display("tb: %0d reserved-word settings after reset, including all-zero and all-one words",
             settings);
    if (fail_count == 0 && tokens_pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
